@@ rtl/crxfd_pkg.sv @@
// Shared types and constants for the CAN receive frame decoder FIFO.
// Used by crxfd_decode, crxfd_fifo, the top level and its checker.
// No dependencies.
`default_nettype none

package crxfd_pkg;

   // FIFO geometry
   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Field widths
   localparam int ID_W     = 29;
   localparam int LEN_W    = 4;
   localparam int PAY_W    = 64;
   localparam int FILL_W   = 5;
   localparam int NUM_BYTE = PAY_W / 8;

   // Stream widths (byte padded)
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 112;

   // Command codes carried in tuser
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Raw image decode constants
   localparam int             EXT_FLAG_BIT = 3;
   localparam int             RTR_FLAG_BIT = 6;
   localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(8);

   // One decoded message as stored in the FIFO
   typedef struct packed {
      logic [LEN_W-1:0] data_length;
      logic             is_remote;
      logic             is_extended;
      logic [ID_W-1:0]  frame_id;
      logic [PAY_W-1:0] payload;
   } msg_type;

   // Operation request to the FIFO
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // FIFO response for the current beat
   typedef struct packed {
      logic              ok;
      logic [FILL_W-1:0] fill;
   } fifo_stat_type;

endpackage : crxfd_pkg

`default_nettype wire

@@ rtl/crxfd_decode.sv @@
// Combinational decode of one raw CAN receive-buffer image into a message.
// Depends on crxfd_pkg.
`default_nettype none

module crxfd_decode
   import crxfd_pkg::*;
(
   input  wire logic [7:0]       id_high_byte,
   input  wire logic [7:0]       id_low_byte,
   input  wire logic [7:0]       ext_mid_byte,
   input  wire logic [7:0]       ext_low_byte,
   input  wire logic [7:0]       length_byte,
   input  wire logic [PAY_W-1:0] payload_raw,
   output msg_type               msg
);

   logic [LEN_W-1:0] raw_len;
   logic [LEN_W-1:0] len;
   logic             ext;
   logic [ID_W-1:0]  id_ext;
   logic [ID_W-1:0]  id_std;
   logic [PAY_W-1:0] masked;

   // Flags and saturated length
   assign ext     = id_low_byte[EXT_FLAG_BIT];
   assign raw_len = length_byte[LEN_W-1:0];
   assign len     = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;

   // Identifier assembly: extended is 8+3+2+8+8 bits, standard is 8+3
   assign id_ext = {id_high_byte, id_low_byte[7:5], id_low_byte[1:0],
                    ext_mid_byte, ext_low_byte};
   assign id_std = {(ID_W - 11)'(0), id_high_byte, id_low_byte[7:5]};

   // Zero payload bytes past the length
   always_comb begin
      for (int i = 0; i < NUM_BYTE; i++) begin
         masked[i*8 +: 8] = (LEN_W'(i) < len) ? payload_raw[i*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      msg.data_length = len;
      msg.is_remote   = length_byte[RTR_FLAG_BIT];
      msg.is_extended = ext;
      msg.frame_id    = ext ? id_ext : id_std;
      msg.payload     = masked;
   end

endmodule : crxfd_decode

`default_nettype wire

@@ rtl/crxfd_fifo.sv @@
// Ring FIFO of decoded messages with registered read data.
// Depends on crxfd_pkg.
`default_nettype none

module crxfd_fifo
   import crxfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fifo_ctrl_type ctrl,
   input  wire msg_type       wr_msg,
   output msg_type            rd_msg,
   output fifo_stat_type      stat
);

   msg_type          mem [FIFO_DEPTH];
   msg_type          rd_msg_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;
   logic             empty;
   logic             do_wr;
   logic             do_rd;

   assign full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = ctrl.push && !full;
   assign do_rd = ctrl.pop && !empty;

   // Pointer and occupancy next state
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write port
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_msg;
      end
   end

   // Storage read port, registered
   always_ff @(posedge clock) begin
      if (do_rd) begin
         rd_msg_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_msg    = rd_msg_ff;
   assign stat.ok   = do_wr || do_rd;
   assign stat.fill = FILL_W'(count_in);

endmodule : crxfd_fifo

`default_nettype wire

@@ rtl/can_rx_frame_decode_fifo.sv @@
// CAN receive frame decoder with message FIFO, top level.
// An accepted request beat goes through the input register, then FIFO update
// and result register. Throughput: one request beat per cycle while the
// response channel is not stalled; one memory port operation per beat.
// Reset: synchronous, active high; empties the FIFO and both pipeline stages.
// Depends on crxfd_pkg, crxfd_decode and crxfd_fifo.
`default_nettype none

module can_rx_frame_decode_fifo
   import crxfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // id_high_byte[7:0], id_low_byte[15:8], ext_mid_byte[23:16],
   // ext_low_byte[31:24], length_byte[39:32], payload_raw[103:40]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  wire logic                  req_tuser,
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // accepted[0], frame_id[29:1], is_extended[30], is_remote[31],
   // data_length[35:32], payload[99:36], fill_count[104:100], zero[111:105]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  in_cmd_ff;
   logic                  rsp_valid_ff;
   logic                  ok_ff;
   logic                  pop_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic                  advance;
   msg_type               dec_msg;
   msg_type               rd_msg;
   msg_type               out_msg;
   fifo_ctrl_type         ctrl;
   fifo_stat_type         stat;

   // Handshake: input stage moves on when the result register is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_cmd_ff  <= req_tuser;
      end
   end

   // Decode of the held image
   crxfd_decode u_decode (
      .id_high_byte (in_data_ff[7:0]),
      .id_low_byte  (in_data_ff[15:8]),
      .ext_mid_byte (in_data_ff[23:16]),
      .ext_low_byte (in_data_ff[31:24]),
      .length_byte  (in_data_ff[39:32]),
      .payload_raw  (in_data_ff[103:40]),
      .msg          (dec_msg)
   );

   // FIFO operation for the beat leaving the input stage
   assign ctrl.push = advance && (in_cmd_ff == CMD_PUSH);
   assign ctrl.pop  = advance && (in_cmd_ff == CMD_POP);

   crxfd_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .wr_msg (dec_msg),
      .rd_msg (rd_msg),
      .stat   (stat)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff   <= stat.ok;
         pop_ff  <= (in_cmd_ff == CMD_POP);
         fill_ff <= stat.fill;
      end
   end

   // Message fields only show for a successful pop
   assign out_msg = (pop_ff && ok_ff) ? rd_msg : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 105)'(0), fill_ff, out_msg.payload,
                        out_msg.data_length, out_msg.is_remote,
                        out_msg.is_extended, out_msg.frame_id, ok_ff};

endmodule : can_rx_frame_decode_fifo

`default_nettype wire

@@ rtl/crxfd_checker.sv @@
// Port-level checker for can_rx_frame_decode_fifo, bound to the top level.
// Depends on crxfd_pkg.
`default_nettype none

module crxfd_checker
   import crxfd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // No response beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Non-accepted beats carry zero message fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[99:1] == '0)
      else $error("rejected beat carries message data");

   // Length never exceeds eight bytes
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:32] <= MAX_LEN)
      else $error("data length above eight");

   // Occupancy never exceeds the FIFO depth
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[104:100]) <= 32'(FIFO_DEPTH))
      else $error("fill count above depth");

endmodule : crxfd_checker

bind can_rx_frame_decode_fifo crxfd_checker u_crxfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ verif/can_rx_frame_decode_fifo_checker.sv @@
// Response checker for can_rx_frame_decode_fifo: watches both stream channels,
// decodes each accepted request beat into its expected response and compares.
// Depends on crxfd_pkg.
module can_rx_frame_decode_fifo_checker
   import crxfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    error_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Response beat layout, lowest bit last in the list
   typedef struct packed {
      logic [RSP_DATA_W-106:0] pad;
      logic [FILL_W-1:0]       fill_count;
      logic [PAY_W-1:0]        payload;
      logic [LEN_W-1:0]        data_length;
      logic                    is_remote;
      logic                    is_extended;
      logic [ID_W-1:0]         frame_id;
      logic                    accepted;
   } outcome_type;

   msg_type     held_messages[$];      // messages the FIFO should hold, oldest first
   outcome_type expected_outcomes[$];  // responses still owed by the block

   // Raw receive-buffer image to decoded message
   function automatic msg_type decode_image(logic [REQ_DATA_W-1:0] image);
      logic [7:0]       id_hi;
      logic [7:0]       id_lo;
      logic [7:0]       ext_mid;
      logic [7:0]       ext_lo;
      logic [7:0]       len_raw;
      logic [LEN_W-1:0] len;
      msg_type          m;
      id_hi   = image[7:0];
      id_lo   = image[15:8];
      ext_mid = image[23:16];
      ext_lo  = image[31:24];
      len_raw = image[39:32];
      len     = (len_raw[3:0] > MAX_LEN) ? MAX_LEN : len_raw[3:0];
      m.data_length = len;
      m.is_remote   = len_raw[RTR_FLAG_BIT];
      m.is_extended = id_lo[EXT_FLAG_BIT];
      if (m.is_extended) begin
         m.frame_id = {id_hi, id_lo[7:5], id_lo[1:0], ext_mid, ext_lo};
      end else begin
         m.frame_id = ID_W'({id_hi, id_lo[7:5]});
      end
      // bytes past the length read as zero
      for (int i = 0; i < NUM_BYTE; i++) begin
         m.payload[i*8 +: 8] = (i < len) ? image[40 + i*8 +: 8] : 8'h00;
      end
      return m;
   endfunction

   // Apply one request to the FIFO image and return the response it earns
   function automatic outcome_type predict_frame_outcome(logic cmd,
                                                         logic [REQ_DATA_W-1:0] image);
      outcome_type o;
      msg_type     m;
      o = '0;
      if (cmd == CMD_PUSH) begin
         if (held_messages.size() < FIFO_DEPTH) begin
            held_messages.push_back(decode_image(image));
            o.accepted = 1'b1;
         end
      end else if (held_messages.size() > 0) begin
         m = held_messages.pop_front();
         o.accepted    = 1'b1;
         o.frame_id    = m.frame_id;
         o.is_extended = m.is_extended;
         o.is_remote   = m.is_remote;
         o.data_length = m.data_length;
         o.payload     = m.payload;
      end
      o.fill_count = FILL_W'(held_messages.size());
      return o;
   endfunction

   // Compare one response beat with the oldest expectation
   task automatic check_response(outcome_type got);
      outcome_type want;
      logic        bad;
      if (expected_outcomes.size() == 0) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: response beat with none expected: %h", $realtime, got);
         end
      end else begin
         want = expected_outcomes.pop_front();
         bad  = (got.accepted    !== want.accepted)    ||
                (got.frame_id    !== want.frame_id)    ||
                (got.is_extended !== want.is_extended) ||
                (got.is_remote   !== want.is_remote)   ||
                (got.data_length !== want.data_length) ||
                (got.payload     !== want.payload)     ||
                (got.fill_count  !== want.fill_count)  ||
                (got.pad         !== want.pad);
         if (bad) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: exp acc=%0d id=%h ext=%0d rtr=%0d len=%0d pay=%h fill=%0d pad=%h",
                        $realtime, want.accepted, want.frame_id, want.is_extended,
                        want.is_remote, want.data_length, want.payload,
                        want.fill_count, want.pad);
               $display("%0t: got acc=%0d id=%h ext=%0d rtr=%0d len=%0d pay=%h fill=%0d pad=%h",
                        $realtime, got.accepted, got.frame_id, got.is_extended,
                        got.is_remote, got.data_length, got.payload,
                        got.fill_count, got.pad);
            end
         end
      end
   endtask

   // Responses are checked before the request of the same edge is predicted:
   // a request can never be answered at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         held_messages.delete();
         expected_outcomes.delete();
         error_count = 0;
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response(outcome_type'(rsp_tdata));
         end
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(predict_frame_outcome(req_tuser, req_tdata));
         end
         outstanding <= expected_outcomes.size();
      end
   end

endmodule

@@ verif/can_rx_frame_decode_fifo_tb.sv @@
// Testbench top for can_rx_frame_decode_fifo: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on crxfd_pkg, the block and can_rx_frame_decode_fifo_checker.
module can_rx_frame_decode_fifo_tb;
   import crxfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1430;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = CMD_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    error_count;
   int                    outstanding;
   int                    src_gap_pct    = 0;
   int                    sink_stall_pct = 0;
   int                    quiet_cycles   = 0;

   can_rx_frame_decode_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   can_rx_frame_decode_fifo_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Response back-pressure
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // One request beat; entered and left at a falling edge.
   // Valid is lowered only for a gap, so it never drops and rises in one step.
   task automatic send_beat(logic cmd, logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic push_image(logic [7:0] id_hi, logic [7:0] id_lo, logic [7:0] ext_mid,
                             logic [7:0] ext_lo, logic [7:0] len_raw,
                             logic [PAY_W-1:0] raw);
      send_beat(CMD_PUSH, {raw, len_raw, ext_lo, ext_mid, id_lo, id_hi});
   endtask

   // Pop beats carry random data, which the block must ignore
   task automatic pop_message();
      send_beat(CMD_POP, REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
   endtask

   // Random image; len_sel >= 0 sets the length, else a quarter get a legal length
   task automatic push_random(int len_sel);
      logic [7:0] len_raw;
      len_raw = 8'($urandom);
      if (len_sel >= 0) begin
         len_raw[3:0] = 4'(len_sel);
      end else if ($urandom_range(3) == 0) begin
         len_raw[3:0] = 4'($urandom_range(8));
      end
      push_image(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), len_raw,
                 {$urandom, $urandom});
   endtask

   initial begin
      int push_pct;
      push_pct = 50;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty pop, field extremes, ignored bits, saturation, full FIFO
      src_gap_pct    = 7;
      sink_stall_pct = 59;
      pop_message();
      // standard id all ones, ignored id_low bits set, zero length hides payload
      push_image(8'hFF, 8'hF7, 8'hFF, 8'hFF, 8'h00, '1);
      // extended id all ones, remote, raw length 15 saturates
      push_image(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1);
      // extended id zero, remote, length 0
      push_image(8'h00, 8'h08, 8'h00, 8'h00, 8'h40, 64'h0);
      // standard id zero, extended bytes ignored, full eight bytes
      push_image(8'h00, 8'h00, 8'hA5, 8'h5A, 8'h08, 64'h0123_4567_89AB_CDEF);
      // raw length 9 with ignored length bits set, ignored id_low bits 4 and 2
      push_image(8'h80, 8'h14, 8'h00, 8'h00, 8'hB9, '1);
      // extended id with low id_low bits set
      push_image(8'h5A, 8'hAB, 8'h3C, 8'hC3, 8'h03, {$urandom, $urandom});
      // fill up and run two pushes into a full FIFO
      for (int i = 0; i < 12; i++) begin
         push_random(i);
      end
      // free one slot and let the write pointer wrap
      pop_message();
      push_random(7);

      // Random traffic in three back-pressure phases
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            src_gap_pct    = 59;
            sink_stall_pct = 7;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
         end
         // swing the push/pop mix so both full and empty are hit often
         if (n % 48 == 0) begin
            case ($urandom_range(2))
               0: begin
                  push_pct = 15;
               end
               1: begin
                  push_pct = 50;
               end
               default: begin
                  push_pct = 85;
               end
            endcase
         end
         if ($urandom_range(99) < push_pct) begin
            push_random(-1);
         end else begin
            pop_message();
         end
      end
      req_tvalid <= 1'b0;

      // Drain and decide
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
